// ===== hdl/ttl_pkg.sv =====
// ----------------------------------------------------------------------------
// ttl_pkg
// Shared types and codes for the text token lexer: scan states, token type
// codes, character constants and the result entry layout.
// ----------------------------------------------------------------------------
`default_nettype none

package ttl_pkg;

  localparam int unsigned STATE_W = 3;
  localparam int unsigned TYPE_W  = 3;
  localparam int unsigned BYTE_W  = 8;

  typedef logic [STATE_W-1:0] scan_state_t;
  typedef logic [TYPE_W-1:0]  token_type_t;
  typedef logic [BYTE_W-1:0]  byte_t;

  localparam scan_state_t ST_IDLE    = 3'd0;
  localparam scan_state_t ST_COMMENT = 3'd1;
  localparam scan_state_t ST_STRING  = 3'd2;
  localparam scan_state_t ST_ESCAPE  = 3'd3;
  localparam scan_state_t ST_NUMBER  = 3'd4;
  localparam scan_state_t ST_SYMBOL  = 3'd5;

  localparam token_type_t TT_STRING   = 3'd0;
  localparam token_type_t TT_NUMBER   = 3'd1;
  localparam token_type_t TT_SYMBOL   = 3'd2;
  localparam token_type_t TT_FINISHED = 3'd3;
  localparam token_type_t TT_ERROR    = 3'd4;

  localparam logic KIND_TEXT = 1'b0;
  localparam logic KIND_END  = 1'b1;

  localparam byte_t CH_HASH   = 8'h23;
  localparam byte_t CH_STAR   = 8'h2A;
  localparam byte_t CH_QUOTE  = 8'h22;
  localparam byte_t CH_BSLASH = 8'h5C;
  localparam byte_t CH_LF     = 8'h0A;
  localparam byte_t CH_CR     = 8'h0D;
  localparam byte_t CH_TAB    = 8'h09;
  localparam byte_t CH_NUL    = 8'h00;
  localparam byte_t CH_SPACE  = 8'h20;
  localparam byte_t CH_ZERO   = 8'h30;
  localparam byte_t CH_NINE   = 8'h39;
  localparam byte_t CH_LOW_N  = 8'h6E;
  localparam byte_t CH_LOW_R  = 8'h72;
  localparam byte_t CH_LOW_T  = 8'h74;
  localparam byte_t CH_GRAPH_LO = 8'h21;
  localparam byte_t CH_GRAPH_HI = 8'h7E;

  typedef struct packed {
    logic        kind;
    token_type_t token_type;
    byte_t       text_byte;
    logic        last;
  } result_t;

  function automatic result_t res_text(input byte_t b);
    result_t r;
    r.kind       = KIND_TEXT;
    r.token_type = TT_STRING;
    r.text_byte  = b;
    r.last       = 1'b0;
    return r;
  endfunction

  function automatic result_t res_end(input token_type_t t);
    result_t r;
    r.kind       = KIND_END;
    r.token_type = t;
    r.text_byte  = '0;
    r.last       = 1'b0;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/text_token_lexer_unit.sv =====
// ----------------------------------------------------------------------------
// text_token_lexer_unit
// Character-at-a-time tokenizer. Skips whitespace and comments, emits token
// bytes (strings with escapes, digit runs, symbols) followed by an end marker.
// ----------------------------------------------------------------------------
// Results are registered: a result is presented the cycle after its input transfer.
// Throughput: one character per cycle while each produces at most one result and
//   out_stall is low; a character producing two results holds the input until the
//   first is taken (two-entry result buffer drains one result per cycle unless stalled).
// Reset: synchronous, active low; scanner returns idle, result buffer empties.
`default_nettype none

module text_token_lexer_unit (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_stall,
  input  wire  ttl_pkg::byte_t  in_char_in,
  input  wire                   in_end_of_input,
  output logic                  out_valid,
  input  wire                   out_stall,
  output logic                  out_kind,
  output ttl_pkg::token_type_t  out_token_type,
  output ttl_pkg::byte_t        out_text_byte,
  output logic                  out_last
);
  import ttl_pkg::*;

  scan_state_t scan_state_r, scan_state_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  result_t     e0_r, e0_nxt, e1_r, e1_nxt;

  logic        in_xfer, out_xfer;
  logic [1:0]  n_res;
  result_t     r0, r1;

  logic        c_space, c_digit, c_graph;
  logic        start_emit;
  result_t     start_res;
  scan_state_t start_st;

  assign out_valid = (cnt_r != 2'd0);
  assign out_xfer  = out_valid && !out_stall;
  assign in_stall  = (cnt_r == 2'd2) || ((cnt_r == 2'd1) && out_stall);
  assign in_xfer   = in_valid && !in_stall;

  assign out_kind       = e0_r.kind;
  assign out_token_type = e0_r.token_type;
  assign out_text_byte  = e0_r.text_byte;
  assign out_last       = e0_r.last;

  assign c_space = (in_char_in == CH_SPACE) || ((in_char_in >= CH_TAB) && (in_char_in <= CH_CR));
  assign c_digit = (in_char_in >= CH_ZERO) && (in_char_in <= CH_NINE);
  assign c_graph = (in_char_in >= CH_GRAPH_LO) && (in_char_in <= CH_GRAPH_HI);

  // token start decode
  always_comb begin
    start_emit = 1'b1;
    start_res  = res_end(TT_ERROR);
    start_st   = ST_IDLE;
    priority if (c_space) begin
      start_emit = 1'b0;
    end else if ((in_char_in == CH_HASH) || (in_char_in == CH_STAR)) begin
      start_emit = 1'b0;
      start_st   = ST_COMMENT;
    end else if (in_char_in == CH_QUOTE) begin
      start_emit = 1'b0;
      start_st   = ST_STRING;
    end else if (c_digit) begin
      start_res = res_text(in_char_in);
      start_st  = ST_NUMBER;
    end else if (c_graph) begin
      start_res = res_text(in_char_in);
      start_st  = ST_SYMBOL;
    end else begin
      start_res = res_end(TT_ERROR);
    end
  end

  // scanner step
  always_comb begin
    scan_state_nxt = scan_state_r;
    n_res          = 2'd0;
    r0             = res_end(TT_ERROR);
    r1             = res_end(TT_FINISHED);
    if (in_end_of_input) begin
      scan_state_nxt = ST_IDLE;
      if ((scan_state_r == ST_STRING) || (scan_state_r == ST_ESCAPE)) begin
        r0    = res_end(TT_ERROR);
        n_res = 2'd1;
      end else if (scan_state_r == ST_NUMBER) begin
        r0    = res_end(TT_NUMBER);
        n_res = 2'd2;
      end else if (scan_state_r == ST_SYMBOL) begin
        r0    = res_end(TT_SYMBOL);
        n_res = 2'd2;
      end else begin
        r0    = res_end(TT_FINISHED);
        n_res = 2'd1;
      end
    end else begin
      unique case (scan_state_r)
        ST_COMMENT: begin
          if (in_char_in == CH_LF) scan_state_nxt = ST_IDLE;
        end
        ST_STRING: begin
          priority if (in_char_in == CH_QUOTE) begin
            r0             = res_end(TT_STRING);
            n_res          = 2'd1;
            scan_state_nxt = ST_IDLE;
          end else if (in_char_in == CH_LF) begin
            r0             = res_end(TT_ERROR);
            n_res          = 2'd1;
            scan_state_nxt = ST_IDLE;
          end else if (in_char_in == CH_BSLASH) begin
            scan_state_nxt = ST_ESCAPE;
          end else begin
            r0    = res_text(in_char_in);
            n_res = 2'd1;
          end
        end
        ST_ESCAPE: begin
          n_res          = 2'd1;
          scan_state_nxt = ST_STRING;
          unique case (in_char_in)
            CH_LOW_N:  r0 = res_text(CH_LF);
            CH_LOW_R:  r0 = res_text(CH_CR);
            CH_ZERO:   r0 = res_text(CH_NUL);
            CH_LOW_T:  r0 = res_text(CH_TAB);
            CH_BSLASH: r0 = res_text(CH_BSLASH);
            CH_QUOTE:  r0 = res_text(CH_QUOTE);
            default: begin
              r0             = res_end(TT_ERROR);
              scan_state_nxt = ST_IDLE;
            end
          endcase
        end
        ST_NUMBER, ST_SYMBOL: begin
          if ((scan_state_r == ST_NUMBER) ? c_digit : c_graph) begin
            r0    = res_text(in_char_in);
            n_res = 2'd1;
          end else begin
            r0             = res_end((scan_state_r == ST_NUMBER) ? TT_NUMBER : TT_SYMBOL);
            r1             = start_res;
            n_res          = start_emit ? 2'd2 : 2'd1;
            scan_state_nxt = start_st;
          end
        end
        default: begin
          r0             = start_res;
          n_res          = start_emit ? 2'd1 : 2'd0;
          scan_state_nxt = start_st;
        end
      endcase
    end
    r0.last = (n_res == 2'd1);
    r1.last = 1'b1;
  end

  // result buffer
  always_comb begin
    cnt_nxt = cnt_r;
    e0_nxt  = e0_r;
    e1_nxt  = e1_r;
    if (in_xfer) begin
      cnt_nxt = n_res;
      e0_nxt  = r0;
      e1_nxt  = r1;
    end else if (out_xfer) begin
      cnt_nxt = cnt_r - 2'd1;
      e0_nxt  = e1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_state_r <= ST_IDLE;
      cnt_r        <= 2'd0;
    end else begin
      if (in_xfer) scan_state_r <= scan_state_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    e0_r <= e0_nxt;
    e1_r <= e1_nxt;
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("result buffer count out of range");

  a_pair_last: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2) |-> (!e0_r.last && e1_r.last))
    else $error("two buffered results with wrong last flags");

  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd1) |-> e0_r.last) else $error("single buffered result not last");

  a_eoi_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_end_of_input) |=> (scan_state_r == ST_IDLE))
    else $error("scanner not idle after end of input");

endmodule

`default_nettype wire
